// ===== sv/sic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_pkg: shared types and constants of the stream inversion counter
// Field widths, error codes and the item/result records passed between the
// stream interface and the counting core.
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int unsigned VALUE_W    = 11;
  localparam int unsigned GB_W       = 10;
  localparam int unsigned RT_W       = 19;
  localparam int unsigned TOTAL_W    = 20;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned EPOCH_W    = 8;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 11'd1024;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 2'd0,
    ERR_RANGE    = 2'd1,
    ERR_CAPACITY = 2'd2
  } sic_err_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               start_new;
  } sic_item_t;

  typedef struct packed {
    logic [GB_W-1:0] greater;
    logic [RT_W-1:0] total;
    sic_err_e        err;
  } sic_result_t;

endpackage

// ===== sv/sic_count_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_count_ram: tagged count memory
// One write and one registered read per cycle. Each entry carries the epoch
// it was written in; an entry from an older epoch reads as zero.
// ----------------------------------------------------------------------------
module sic_count_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned CW    = 11,
  parameter int unsigned EW    = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [CW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  input  logic [EW-1:0]            epoch_i,
  output logic [CW-1:0]            rdata_o
);

  logic [EW+CW-1:0] mem_q [DEPTH];
  logic [EW+CW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {epoch_i, wdata_i};
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  // stale epoch means the entry was cleared by a later start
  assign rdata_o = (rd_q[EW+CW-1:CW] == epoch_i) ? rd_q[CW-1:0] : '0;

endmodule

// ===== sv/sic_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_core: inversion counting sequencer
// Walks a binary indexed count tree one node per cycle: two prefix sums give
// the count of greater earlier values, then an update walk adds the value.
// A single adder serves both the sum accumulation and the node increments.
// ----------------------------------------------------------------------------
module sic_core #(
  parameter int unsigned MAX_VALUES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  sic_pkg::sic_item_t            item_i,
  input  logic [sic_pkg::VALUE_W-1:0]   max_value_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output sic_pkg::sic_result_t          res_o
);
  import sic_pkg::*;

  localparam int unsigned CW = $clog2(MAX_VALUES + 1);
  localparam int unsigned XW = CW + 1;
  localparam int unsigned AW = $clog2(MAX_VALUES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_QHI,
    ST_QLO,
    ST_UPD,
    ST_SUM,
    ST_RESULT
  } state_e;

  typedef enum logic [1:0] {
    RK_NONE,
    RK_ADD,
    RK_SUB,
    RK_UPD
  } rd_kind_e;

  state_e              state_q, state_d;
  rd_kind_e            rd_kind_q, rd_kind_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic                pend_q, pend_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic [XW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       v_q, v_d;
  logic [CW-1:0]       lim_q, lim_d;
  logic                bad_q, bad_d;
  logic [CW-1:0]       items_q, items_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [CW-1:0]       acc_q, acc_d;
  logic [AW-1:0]       wr_addr_q, wr_addr_d;
  sic_err_e            err_q, err_d;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [CW-1:0]       mem_wdata, mem_rdata;

  logic [CW-1:0]       add_a, add_b, add_sum;
  logic [XW-1:0]       idx_m1, idx_low, idx_clr, idx_up;
  logic [AW-1:0]       node_addr;
  logic [31:0]         max_ext, lim_full, value_ext;

  sic_count_ram #(
    .DEPTH(MAX_VALUES),
    .CW   (CW),
    .EW   (EPOCH_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .epoch_i(epoch_q),
    .rdata_o(mem_rdata)
  );

  // tree index arithmetic
  assign idx_m1    = idx_q - XW'(1);
  assign idx_low   = idx_q & (~idx_q + XW'(1));
  assign idx_clr   = idx_q & idx_m1;
  assign idx_up    = idx_q + idx_low;
  assign node_addr = idx_m1[AW-1:0];

  // limit in use and range check
  assign max_ext   = 32'(max_value_i);
  assign lim_full  = (max_ext > MAX_VALUES) ? MAX_VALUES : max_ext;
  assign value_ext = 32'(item_i.value);

  // shared adder
  always_comb begin
    if (rd_kind_q == RK_UPD) begin
      add_a = mem_rdata;
      add_b = CW'(1);
    end else begin
      add_a = acc_q;
      add_b = (rd_kind_q == RK_SUB) ? (~mem_rdata + CW'(1)) : mem_rdata;
    end
  end
  assign add_sum = add_a + add_b;

  always_comb begin
    state_d   = state_q;
    rd_kind_d = RK_NONE;
    clr_d     = clr_q;
    pend_d    = pend_q;
    epoch_d   = epoch_q;
    idx_d     = idx_q;
    v_d       = v_q;
    lim_d     = lim_q;
    bad_d     = bad_q;
    items_d   = items_q;
    total_d   = total_q;
    acc_d     = acc_q;
    wr_addr_d = wr_addr_q;
    err_d     = err_q;
    mem_re    = 1'b0;
    mem_raddr = node_addr;
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = add_sum;

    // returning read data of the previous cycle
    unique case (rd_kind_q)
      RK_ADD, RK_SUB: acc_d = add_sum;
      RK_UPD:         mem_we = 1'b1;
      RK_NONE:        ;
      default:        ;
    endcase

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == AW'(MAX_VALUES - 1)) begin
          clr_d   = '0;
          pend_d  = 1'b0;
          state_d = pend_q ? ST_CHECK : ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          v_d     = CW'(value_ext);
          lim_d   = CW'(lim_full);
          bad_d   = (value_ext == 32'd0) || (value_ext > lim_full);
          state_d = ST_CHECK;
          if (item_i.start_new) begin
            total_d = '0;
            items_d = '0;
            if (epoch_q == '1) begin
              epoch_d = '0;
              clr_d   = '0;
              pend_d  = 1'b1;
              state_d = ST_CLEAR;
            end else begin
              epoch_d = epoch_q + EPOCH_W'(1);
            end
          end
        end
      end
      ST_CHECK: begin
        acc_d = '0;
        priority if (bad_q) begin
          err_d   = ERR_RANGE;
          state_d = ST_RESULT;
        end else if (32'(items_q) >= MAX_VALUES) begin
          err_d   = ERR_CAPACITY;
          state_d = ST_RESULT;
        end else begin
          err_d   = ERR_OK;
          idx_d   = XW'(lim_q);
          state_d = ST_QHI;
        end
      end
      ST_QHI: begin
        if (idx_q != '0) begin
          mem_re    = 1'b1;
          rd_kind_d = RK_ADD;
          idx_d     = idx_clr;
        end else begin
          idx_d   = XW'(v_q);
          state_d = ST_QLO;
        end
      end
      ST_QLO: begin
        if (idx_q != '0) begin
          mem_re    = 1'b1;
          rd_kind_d = RK_SUB;
          idx_d     = idx_clr;
        end else begin
          idx_d   = XW'(v_q);
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (idx_q <= XW'(MAX_VALUES)) begin
          mem_re    = 1'b1;
          rd_kind_d = RK_UPD;
          wr_addr_d = node_addr;
          idx_d     = idx_up;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        total_d = total_q + TOTAL_W'(acc_q);
        items_d = items_q + CW'(1);
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      rd_kind_q <= RK_NONE;
      clr_q     <= '0;
      pend_q    <= 1'b0;
      epoch_q   <= '0;
      items_q   <= '0;
      total_q   <= '0;
      err_q     <= ERR_OK;
    end else begin
      state_q   <= state_d;
      rd_kind_q <= rd_kind_d;
      clr_q     <= clr_d;
      pend_q    <= pend_d;
      epoch_q   <= epoch_d;
      items_q   <= items_d;
      total_q   <= total_d;
      err_q     <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    v_q       <= v_d;
    lim_q     <= lim_d;
    bad_q     <= bad_d;
    acc_q     <= acc_d;
    wr_addr_q <= wr_addr_d;
  end

  assign item_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o   = (state_q == ST_RESULT);
  assign res_o.greater = (err_q == ERR_OK) ? GB_W'(acc_q) : '0;
  assign res_o.total   = total_q[RT_W-1:0];
  assign res_o.err     = err_q;

endmodule

// ===== sv/stream_inversion_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_inversion_counter: streaming inversion counter
// For each value reports how many earlier values of the sequence are greater,
// plus the running inversion total, using a binary indexed count tree.
// ----------------------------------------------------------------------------
// Each item walks a binary indexed count tree one node per cycle on the single
// read port of the count memory: a prefix sum at the limit in use, a prefix
// sum at the value, and the update walk over the nodes that it touches. The
// walks come after acceptance and the checks and before the total and the
// handoff; an out-of-range or over-capacity item goes from the checks
// straight to the handoff. After reset, and on every 256th start flag, the
// count memory is swept clear, and no item is taken during the sweep.
// A result waits in the output register while the next item is worked on.
module stream_inversion_counter #(
  parameter int unsigned MAX_VALUES = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sic_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // value
  input  logic [0:0]                       s_axis_tuser,  // start_new
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sic_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // greater_before, running_total
  output logic [sic_pkg::ERR_W-1:0]        m_axis_tuser,  // error_code
  input  logic                             cfg_we_i,
  input  logic [sic_pkg::VALUE_W-1:0]      cfg_wdata_i    // max_value
);
  import sic_pkg::*;

  logic [VALUE_W-1:0] max_value_q;
  logic               out_valid_q, out_valid_d;
  sic_result_t        out_q, out_d;
  sic_item_t          item;
  sic_result_t        res;
  logic               res_valid, res_ready;

  assign item.value     = s_axis_tdata[VALUE_W-1:0];
  assign item.start_new = s_axis_tuser[0];

  sic_core #(
    .MAX_VALUES(MAX_VALUES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(s_axis_tvalid),
    .item_ready_o(s_axis_tready),
    .item_i      (item),
    .max_value_i (max_value_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MAX_VALUE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_value_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - GB_W - RT_W)'(0), out_q.total, out_q.greater};
  assign m_axis_tuser  = out_q.err;

  // core is busy in the cycle after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while previous item still in work");

  // rejected items report no greater values
  a_err_zero_greater: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ERR_OK) |-> (m_axis_tdata[GB_W-1:0] == '0))
    else $error("error result with nonzero greater count");

  // a new result only follows a cycle in which the core held it
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without core handoff");

endmodule
